>>> sv/lbhd_pkg.sv
// ----------------------------------------------------------------------------
// lbhd_pkg
// Types, codes and reset constants shared by the light barrier detector.
// ----------------------------------------------------------------------------
package lbhd_pkg;

  // Width of the sample field and of the thresholds
  localparam int SAMPLE_W    = 12;
  // Significant ADC bits; the sample is masked to this many bits
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_W     = 8;
  localparam int COOL_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SAMPLE_W-1:0] DARK_THRESHOLD_RST  = SAMPLE_W'(300);
  localparam logic [SAMPLE_W-1:0] LIGHT_THRESHOLD_RST = SAMPLE_W'(800);
  localparam logic                DARK_BELOW_RST      = 1'b1;
  localparam logic [COUNT_W-1:0]  STABLE_COUNT_RST    = COUNT_W'(5);
  localparam logic [COOL_W-1:0]   COOLDOWN_LEN_RST    = COOL_W'(800);

  typedef enum logic [2:0] {
    OP_SAMPLE      = 3'd0,
    OP_TICK        = 3'd1,
    OP_MANUAL_ON   = 3'd2,
    OP_MANUAL_OFF  = 3'd3,
    OP_TOGGLE      = 3'd4,
    OP_SENSOR_EN   = 3'd5,
    OP_SENSOR_DIS  = 3'd6,
    OP_REARM       = 3'd7
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_THRESHOLD  = 3'd0,
    CFG_LIGHT_THRESHOLD = 3'd1,
    CFG_DARK_BELOW      = 3'd2,
    CFG_STABLE_COUNT    = 3'd3,
    CFG_COOLDOWN_LEN    = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SET   = 2'd1;
  localparam logic [1:0] EV_CLEAR = 2'd2;

  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_ON   = 2'd1;
  localparam logic [1:0] CHG_OFF  = 2'd2;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ok;
  } in_item_t;

  typedef struct packed {
    logic       active;
    logic       manual_flag;
    logic       sensor_flag;
    logic [1:0] sensor_event;
    logic [1:0] active_change;
    logic       by_manual;
  } out_item_t;

endpackage

>>> sv/light_barrier_hysteresis_detector.sv
// ----------------------------------------------------------------------------
// light_barrier_hysteresis_detector
// Debounced hysteresis detector turning light sensor samples and control
// operations into a latched shadow flag and a combined active state.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transfer (sample, tick, manual on/off, toggle,
//           sensor enable/disable, rearm) with the ADC sample and its ok bit.
//   out_* : exactly one result per input transfer, in order: active, manual
//           and sensor flags, sensor event and change of the active state.
//   cfg_* : register writes (thresholds, polarity, stable count, cooldown),
//           only while the block is idle.
// The state update and the result are computed in the cycle of the input
// transfer and the result sits in the output register on the next cycle.
// Throughput is one item per clock while the receiver takes each result, set
// by the single result register. in_ready is high only while that register is
// empty or its pending result is taken in the same cycle.
// Reset (synchronous) restores the register defaults, clears manual and
// sensor flags, enables the sensor and loads the cooldown with 800 ticks.
// ----------------------------------------------------------------------------
module light_barrier_hysteresis_detector
  import lbhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  // configuration
  logic [SAMPLE_W-1:0] dark_threshold;
  logic [SAMPLE_W-1:0] light_threshold;
  logic                dark_below;
  logic [COUNT_W-1:0]  stable_count;
  logic [COOL_W-1:0]   cooldown_len;

  // detector state
  logic               active_reg,    active_next;
  logic               manual_reg,    manual_next;
  logic               sensor_reg,    sensor_next;
  logic               enabled_reg,   enabled_next;
  logic [COUNT_W-1:0] dark_run,      dark_run_next;
  logic [COUNT_W-1:0] light_run,     light_run_next;
  logic [COOL_W-1:0]  cooldown_left, cooldown_left_next;

  out_item_t result_next;
  logic      in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold  <= DARK_THRESHOLD_RST;
      light_threshold <= LIGHT_THRESHOLD_RST;
      dark_below      <= DARK_BELOW_RST;
      stable_count    <= STABLE_COUNT_RST;
      cooldown_len    <= COOLDOWN_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DARK_THRESHOLD:  dark_threshold  <= cfg_data[SAMPLE_W-1:0];
        CFG_LIGHT_THRESHOLD: light_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_DARK_BELOW:      dark_below      <= cfg_data[0];
        CFG_STABLE_COUNT:    stable_count    <= cfg_data[COUNT_W-1:0];
        CFG_COOLDOWN_LEN:    cooldown_len    <= cfg_data[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [SAMPLE_W-1:0] s;
    logic                dark;
    logic                light;
    logic [COUNT_W-1:0]  run;
    logic                restart;
    logic                reload;
    logic [1:0]          event_code;
    logic                wanted;

    s          = in_data.sample & SAMPLE_MASK;
    dark       = dark_below ? (s < dark_threshold) : (s > dark_threshold);
    light      = dark_below ? (s > light_threshold) : (s < light_threshold);
    run        = '0;
    restart    = 1'b0;
    reload     = 1'b0;
    event_code = EV_NONE;

    manual_next        = manual_reg;
    sensor_next        = sensor_reg;
    enabled_next       = enabled_reg;
    dark_run_next      = dark_run;
    light_run_next     = light_run;
    cooldown_left_next = cooldown_left;

    unique case (in_data.op)
      OP_SAMPLE: begin
        if (enabled_reg && in_data.sample_ok) begin
          if (!sensor_reg) begin
            // saturating run of dark samples
            if (dark) run = (dark_run < stable_count) ? dark_run + 1'b1 : stable_count;
            dark_run_next = run;
            if (run >= stable_count && cooldown_left == '0) begin
              restart     = 1'b1;
              reload      = 1'b1;
              event_code  = EV_SET;
            end
          end else begin
            if (light) run = (light_run < stable_count) ? light_run + 1'b1 : stable_count;
            light_run_next = run;
            if (run >= stable_count) begin
              restart    = 1'b1;
              reload     = 1'b1;
              event_code = EV_CLEAR;
            end
          end
        end
      end
      OP_TICK: begin
        if (cooldown_left != '0) cooldown_left_next = cooldown_left - 1'b1;
      end
      OP_MANUAL_ON: manual_next = 1'b1;
      OP_MANUAL_OFF: begin
        manual_next = 1'b0;
        restart     = 1'b1;
        reload      = 1'b1;
      end
      OP_TOGGLE: begin
        if (!active_reg) begin
          manual_next = 1'b1;
        end else begin
          manual_next = 1'b0;
          restart     = 1'b1;
          reload      = 1'b1;
        end
      end
      OP_SENSOR_EN: enabled_next = 1'b1;
      OP_SENSOR_DIS: begin
        enabled_next = 1'b0;
        restart      = 1'b1;
      end
      OP_REARM: begin
        restart = 1'b1;
        reload  = 1'b1;
      end
      default: ;
    endcase

    if (restart) begin
      dark_run_next  = '0;
      light_run_next = '0;
      sensor_next    = (event_code == EV_SET);
    end
    if (reload) cooldown_left_next = cooldown_len;

    wanted      = manual_next | sensor_next;
    active_next = wanted;

    result_next.active       = wanted;
    result_next.manual_flag  = manual_next;
    result_next.sensor_flag  = sensor_next;
    result_next.sensor_event = event_code;
    result_next.by_manual    = 1'b0;
    if (wanted == active_reg) begin
      result_next.active_change = CHG_NONE;
    end else if (wanted) begin
      result_next.active_change = CHG_ON;
      result_next.by_manual     = manual_next;
    end else begin
      result_next.active_change = CHG_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_reg    <= 1'b0;
      manual_reg    <= 1'b0;
      sensor_reg    <= 1'b0;
      enabled_reg   <= 1'b1;
      dark_run      <= '0;
      light_run     <= '0;
      cooldown_left <= COOLDOWN_LEN_RST;
    end else if (in_xfer) begin
      active_reg    <= active_next;
      manual_reg    <= manual_next;
      sensor_reg    <= sensor_next;
      enabled_reg   <= enabled_next;
      dark_run      <= dark_run_next;
      light_run     <= light_run_next;
      cooldown_left <= cooldown_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) out_data <= result_next;
  end

endmodule

>>> sv/lbhd_checker.sv
// ----------------------------------------------------------------------------
// lbhd_checker
// Port-level checks for the light barrier detector, bound to the top level.
// ----------------------------------------------------------------------------
module lbhd_port_checks
  import lbhd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // active value of the last result handed over
  logic last_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_active <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_active <= out_data.active;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_change_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.active_change == CHG_NONE && out_data.active == last_active) ||
                  (out_data.active_change == CHG_ON && out_data.active && !last_active) ||
                  (out_data.active_change == CHG_OFF && !out_data.active && last_active))
    else $error("active_change does not match previous result");

  a_active_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.active == (out_data.manual_flag | out_data.sensor_flag))
    else $error("active is not manual OR sensor");

  a_by_manual: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.by_manual |->
      out_data.active_change == CHG_ON && out_data.manual_flag)
    else $error("by_manual outside a manual activation");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind light_barrier_hysteresis_detector lbhd_port_checks u_lbhd_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/lbhd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbhd_checker
// Watches the input, output and register ports of the light barrier
// detector. It keeps its own copy of the thresholds, counters and flags,
// predicts one result per input transfer and compares each output transfer
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lbhd_checker
  import lbhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count,
  output int                    result_count
);

  localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // register copy
  logic [SAMPLE_W-1:0] thr_dark, thr_light;
  logic                dark_low;
  logic [COUNT_W-1:0]  need_cnt;
  logic [COOL_W-1:0]   cool_reload;

  // detector state copy
  logic               act_q, man_q, sens_q, en_q;
  logic [COUNT_W-1:0] dark_cnt, light_cnt;
  logic [COOL_W-1:0]  cool_left;

  out_item_t expected_results[$];
  out_item_t pred_res, oldest_res;
  int        fails = 0;
  int        nres  = 0;

  function automatic logic [COUNT_W-1:0] run_next(logic [COUNT_W-1:0] run, logic hit);
    if (!hit) return '0;
    return (run < need_cnt) ? run + 1'b1 : need_cnt;
  endfunction

  task automatic clear_sensor();
    sens_q    = 1'b0;
    dark_cnt  = '0;
    light_cnt = '0;
  endtask

  task automatic load_defaults();
    thr_dark    = DARK_THRESHOLD_RST;
    thr_light   = LIGHT_THRESHOLD_RST;
    dark_low    = DARK_BELOW_RST;
    need_cnt    = STABLE_COUNT_RST;
    cool_reload = COOLDOWN_LEN_RST;
    act_q       = 1'b0;
    man_q       = 1'b0;
    en_q        = 1'b1;
    clear_sensor();
    cool_left   = COOLDOWN_LEN_RST;
  endtask

  task automatic predict_detector(input in_item_t it, output out_item_t r);
    logic [1:0]          ev, chg;
    logic                bym, want, hit;
    logic [SAMPLE_W-1:0] s;
    ev  = EV_NONE;
    chg = CHG_NONE;
    bym = 1'b0;
    s   = it.sample & SMP_MASK;
    case (it.op)
      OP_SAMPLE: begin
        if (en_q && it.sample_ok) begin
          if (!sens_q) begin
            hit      = dark_low ? (s < thr_dark) : (s > thr_dark);
            dark_cnt = run_next(dark_cnt, hit);
            if (dark_cnt >= need_cnt && cool_left == '0) begin
              clear_sensor();
              sens_q    = 1'b1;
              cool_left = cool_reload;
              ev        = EV_SET;
            end
          end else begin
            hit       = dark_low ? (s > thr_light) : (s < thr_light);
            light_cnt = run_next(light_cnt, hit);
            if (light_cnt >= need_cnt) begin
              clear_sensor();
              cool_left = cool_reload;
              ev        = EV_CLEAR;
            end
          end
        end
      end
      OP_TICK: begin
        if (cool_left != '0) cool_left = cool_left - 1'b1;
      end
      OP_MANUAL_ON: man_q = 1'b1;
      OP_TOGGLE: begin
        if (!act_q) begin
          man_q = 1'b1;
        end else begin
          man_q = 1'b0;
          clear_sensor();
          cool_left = cool_reload;
        end
      end
      OP_MANUAL_OFF: begin
        man_q = 1'b0;
        clear_sensor();
        cool_left = cool_reload;
      end
      OP_SENSOR_EN: en_q = 1'b1;
      OP_SENSOR_DIS: begin
        en_q = 1'b0;
        clear_sensor();
      end
      default: begin // rearm
        clear_sensor();
        cool_left = cool_reload;
      end
    endcase
    want = man_q | sens_q;
    if (want != act_q) begin
      act_q = want;
      if (want) begin
        chg = CHG_ON;
        bym = man_q;
      end else begin
        chg = CHG_OFF;
      end
    end
    r.active        = act_q;
    r.manual_flag   = man_q;
    r.sensor_flag   = sens_q;
    r.sensor_event  = ev;
    r.active_change = chg;
    r.by_manual     = bym;
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      load_defaults();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DARK_THRESHOLD:  thr_dark    = cfg_data[SAMPLE_W-1:0];
          CFG_LIGHT_THRESHOLD: thr_light   = cfg_data[SAMPLE_W-1:0];
          CFG_DARK_BELOW:      dark_low    = cfg_data[0];
          CFG_STABLE_COUNT:    need_cnt    = cfg_data[COUNT_W-1:0];
          CFG_COOLDOWN_LEN:    cool_reload = cfg_data[COOL_W-1:0];
          default: ;
        endcase
      end
      // a result leaving now belongs to an earlier input transfer
      if (out_valid && out_ready) begin
        nres++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fails++;
        end else begin
          oldest_res = expected_results.pop_front();
          check_field("active", oldest_res.active, out_data.active);
          check_field("manual_flag", oldest_res.manual_flag, out_data.manual_flag);
          check_field("sensor_flag", oldest_res.sensor_flag, out_data.sensor_flag);
          check_field("sensor_event", oldest_res.sensor_event, out_data.sensor_event);
          check_field("active_change", oldest_res.active_change, out_data.active_change);
          check_field("by_manual", oldest_res.by_manual, out_data.by_manual);
        end
      end
      if (in_valid && in_ready) begin
        predict_detector(in_data, pred_res);
        expected_results.push_back(pred_res);
      end
    end
    pending_count <= expected_results.size();
    fail_count    <= fails;
    result_count  <= nres;
  end

endmodule

>>> tb/light_barrier_hysteresis_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_barrier_hysteresis_detector_tb
// Drives the detector with a short directed sequence and then with bursts of
// dark, light and noisy samples mixed with ticks and control operations,
// across several register settings and idle/stall phases. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module light_barrier_hysteresis_detector_tb;
  import lbhd_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 8;
  localparam int SMP_MAX      = (1 << SAMPLE_W) - 1;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count, pending_count, result_count;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  int items_sent    = 0;
  int settings_used = 1;

  // mirror of the registers, used to aim samples at the thresholds and to size bursts and tick runs
  int cur_dark = DARK_THRESHOLD_RST;
  int cur_light = LIGHT_THRESHOLD_RST;
  bit cur_pol = DARK_BELOW_RST;
  int cur_need = STABLE_COUNT_RST;
  int cur_cool = COOLDOWN_LEN_RST;

  always #4 clk = ~clk;

  light_barrier_hysteresis_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lbhd_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_op(input op_t op, input int s, input bit ok);
    in_item_t it;
    it.op        = op;
    it.sample    = SAMPLE_W'(s);
    it.sample_ok = ok;
    push_item(it);
  endtask

  // control op with random, unused sample bits
  task automatic send_ctrl(input op_t op);
    send_op(op, $urandom_range(SMP_MAX), $urandom_range(1));
  endtask

  // kind 0: dark, 1: light, else anything
  function automatic int pick_sample(int kind);
    if (kind == 0)
      return cur_pol ? $urandom_range(cur_dark) : $urandom_range(SMP_MAX, cur_dark);
    if (kind == 1)
      return cur_pol ? $urandom_range(SMP_MAX, cur_light) : $urandom_range(cur_light);
    return $urandom_range(SMP_MAX);
  endfunction

  task automatic send_burst();
    int  kind, len, r, nticks;
    op_t op;
    kind = $urandom_range(2);
    len  = $urandom_range(1, cur_need + 2);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 85)
        send_op(OP_SAMPLE, pick_sample(kind), $urandom_range(99) < 93);
      else if (r < 95)
        send_ctrl(OP_TICK);
      else
        send_ctrl(op_t'($urandom_range(7)));
    end
    nticks = $urandom_range(0, (cur_cool < 8) ? cur_cool + 1 : 8);
    repeat (nticks) send_ctrl(OP_TICK);
    if ($urandom_range(99) < 25) begin
      op = op_t'($urandom_range(OP_MANUAL_ON, OP_REARM));
      send_ctrl(op);
      if (op == OP_SENSOR_DIS && $urandom_range(99) < 70) send_ctrl(OP_SENSOR_EN);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom_range(16'hFFFF));
    for (int b = 0; b < width; b++) d[b] = value[b];
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_regs(input int dk, input int lt, input bit pol, input int need,
                          input int cool);
    cur_dark  = dk;
    cur_light = lt;
    cur_pol   = pol;
    cur_need  = need;
    cur_cool  = cool;
    write_reg(CFG_DARK_THRESHOLD, dk, SAMPLE_W);
    write_reg(CFG_LIGHT_THRESHOLD, lt, SAMPLE_W);
    write_reg(CFG_DARK_BELOW, pol, 1);
    write_reg(CFG_STABLE_COUNT, need, COUNT_W);
    write_reg(CFG_COOLDOWN_LEN, cool, COOL_W);
    // index past the register list, must be ignored
    write_reg(CFG_IDX_W'(CFG_COOLDOWN_LEN + $urandom_range(1, 3)),
              $urandom_range(16'hFFFF), CFG_DATA_W);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic phase_regs(input int p);
    int dk, lt, need, cool;
    dk   = $urandom_range(SMP_MAX);
    lt   = $urandom_range(SMP_MAX);
    need = $urandom_range(1, 4);
    cool = $urandom_range(0, 6);
    if (p == 2) begin
      dk = 0;
      lt = SMP_MAX;
    end
    if (p == 5) begin
      dk = SMP_MAX;
      lt = 0;
    end
    if (p == 3) need = 255;
    if (p == 6) need = 0;
    if (p == 3 || p == 7) cool = 0;
    if (p == 4) cool = 16'hFFFF;
    set_regs(dk, lt, p % 2 == 0, need, cool);
  endtask

  initial begin
    int start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    send_op(OP_SAMPLE, 0, 1'b1);
    send_op(OP_SAMPLE, SMP_MAX, 1'b0);      // failed read
    send_ctrl(OP_TICK);
    send_ctrl(OP_MANUAL_ON);
    send_ctrl(OP_TOGGLE);                   // toggle while active
    send_ctrl(OP_TOGGLE);                   // toggle while inactive
    send_ctrl(OP_SENSOR_DIS);
    send_op(OP_SAMPLE, 0, 1'b1);            // ignored, sensor disabled
    send_ctrl(OP_SENSOR_EN);
    send_ctrl(OP_REARM);
    send_ctrl(OP_MANUAL_OFF);
    drain();
    // zero stable count; cooldown write leaves the running cooldown alone
    set_regs(DARK_THRESHOLD_RST, LIGHT_THRESHOLD_RST, 1'b1, 0, 0);
    send_op(OP_SAMPLE, 2000, 1'b1);
    send_ctrl(OP_REARM);
    send_op(OP_SAMPLE, 2000, 1'b1);
    send_op(OP_SAMPLE, 2000, 1'b1);
    send_op(OP_SAMPLE, SMP_MAX, 1'b1);
    drain();
    set_regs(DARK_THRESHOLD_RST, LIGHT_THRESHOLD_RST, 1'b1, 2, 1);
    send_ctrl(OP_REARM);
    send_op(OP_SAMPLE, 100, 1'b1);
    send_op(OP_SAMPLE, 100, 1'b1);          // run full, cooldown still pending
    send_ctrl(OP_TICK);
    send_op(OP_SAMPLE, 100, 1'b1);          // saturated run sets the flag
    send_op(OP_SAMPLE, 4000, 1'b1);
    send_op(OP_SAMPLE, 4000, 1'b1);
    send_ctrl(OP_MANUAL_ON);
    send_ctrl(OP_MANUAL_OFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      phase_regs(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      if (p == 1) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_burst();
    end
    drain();

    $display("summary: %0d items sent, %0d results checked, %0d register settings",
             items_sent, result_count, settings_used);
    $display("summary: idle and stall phases, long receiver hold-off, extreme thresholds");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
